### rtl/core/smft_pkg.sv
// ============================================================================
// smft_pkg: shared types and constants for the flash translation unit
// Holds the beat structs, command and status codes and default sizes.
// ============================================================================
package smft_pkg;

    localparam int PagesInBlock = 8;
    localparam int BlockCount   = 16;
    localparam int LogicalPages = 120;

    localparam logic [2:0] CMD_READ       = 3'd0;
    localparam logic [2:0] CMD_PROGRAM    = 3'd1;
    localparam logic [2:0] CMD_INVALIDATE = 3'd2;
    localparam logic [2:0] CMD_COPY       = 3'd3;
    localparam logic [2:0] CMD_ERASE      = 3'd4;
    localparam logic [2:0] CMD_NONE       = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    localparam logic [1:0] MK_ERASED  = 2'd0;
    localparam logic [1:0] MK_VALID   = 2'd1;
    localparam logic [1:0] MK_INVALID = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [6:0] logical_page;
    } t_req;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] target_page;
        logic [6:0] source_page;
        logic [3:0] erase_block;
        logic [6:0] page_owner;
        logic [1:0] status;
        logic       last;
    } t_rsp;

endpackage

### rtl/core/sector_map_flash_translation_unit.sv
// ============================================================================
// sector_map_flash_translation_unit: sector-mapped flash translation control
// Maps logical pages to physical pages with greedy garbage collection and
// emits a run of flash command beats per request.
// ============================================================================
// Usage: one request beat (i_req, read or write of a logical page) enters on
// i_req_valid / o_req_stall. Each request yields one to PAGES_IN_BLOCK+2
// command beats on o_rsp_valid / i_rsp_stall; the final beat has last = 1.
// The request side stalls from acceptance until the last beat is taken.
// Timing is set by one sequencer over the page/block state. A write scans
// the pages for the lowest erased one outside the spare block, each page
// taking a registered mark read, then the test; a collection adds a block
// scan, a walk over the pages of the victim block and a second page scan.
// Any receiver stall simply holds the sequencer in place with the beat on
// the port.
// After reset a clearing pass walks the page mark and forward map stores,
// one entry per cycle, while the request side stalls. The spare block
// resets to the last block.
// ============================================================================
module sector_map_flash_translation_unit #(
    parameter int PAGES_IN_BLOCK = smft_pkg::PagesInBlock,
    parameter int BLOCK_COUNT    = smft_pkg::BlockCount,
    parameter int LOGICAL_PAGES  = smft_pkg::LogicalPages
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  smft_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output smft_pkg::t_rsp  o_rsp
);
    localparam int TP  = PAGES_IN_BLOCK * BLOCK_COUNT;
    localparam int PW  = $clog2(TP);
    localparam int BW  = $clog2(BLOCK_COUNT);
    localparam int OW  = $clog2(PAGES_IN_BLOCK);
    localparam int LW  = (LOGICAL_PAGES > 1) ? $clog2(LOGICAL_PAGES) : 1;
    localparam int CW  = $clog2(PAGES_IN_BLOCK + 1);
    localparam int CLR = (TP > LOGICAL_PAGES) ? TP : LOGICAL_PAGES;
    localparam int XW  = $clog2(CLR + 1);

    localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_RD = 5'd2,
                           S_RDOUT = 5'd3,  S_SCAN = 5'd4,  S_GCB = 5'd5,
                           S_GCP  = 5'd6,   S_GCPR = 5'd7,  S_COPY = 5'd8,
                           S_ERASE = 5'd9,  S_SCAN2 = 5'd10, S_FMRD = 5'd11,
                           S_FMR  = 5'd12,  S_INV = 5'd13,  S_PROG = 5'd14,
                           S_NONE = 5'd15,  S_OUT = 5'd16,  S_INVM = 5'd17;

    // Stores
    logic [1:0]    mark_mem [TP];
    logic [LW-1:0] rev_mem  [TP];
    logic [PW:0]   fwd_mem  [LOGICAL_PAGES];
    logic [CW-1:0] r_inv [BLOCK_COUNT];
    logic [BW-1:0] r_spare;

    logic [4:0]    r_state, r_ret;
    logic [XW-1:0] r_idx;
    logic [6:0]    r_lp;
    logic          r_wr;
    logic [PW-1:0] r_fresh, r_dst, r_old;
    logic [BW-1:0] r_vict;
    logic [CW-1:0] r_best;
    logic          r_found;
    logic          r_chk;
    logic [1:0]    r_mark;
    logic [LW-1:0] r_rev;
    logic [PW:0]   r_fwd;
    logic          r_vld;
    smft_pkg::t_rsp r_rsp;

    logic [PW-1:0] pidx;
    logic          in_lp_ok;
    assign pidx     = r_idx[PW-1:0];
    assign in_lp_ok = ({25'd0, r_lp} < 32'(LOGICAL_PAGES));

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_vld;
    assign o_rsp       = r_rsp;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_vld   <= 1'b0;
            r_chk   <= 1'b0;
            r_spare <= BW'(BLOCK_COUNT - 1);
            for (int b = 0; b < BLOCK_COUNT; b++) r_inv[b] <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (r_idx < XW'(TP)) mark_mem[pidx] <= smft_pkg::MK_ERASED;
                    if (r_idx < XW'(LOGICAL_PAGES)) fwd_mem[r_idx[LW-1:0]] <= '0;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == XW'(CLR - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_lp    <= i_req.logical_page;
                        r_wr    <= i_req.req_type;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_fwd <= fwd_mem[r_lp[LW-1:0]];
                    if (!in_lp_ok) begin
                        r_state <= S_NONE;
                    end else if (!r_wr) begin
                        r_state <= S_RDOUT;
                    end else begin
                        r_idx   <= '0;
                        r_ret   <= S_SCAN;
                        r_state <= S_SCAN;
                    end
                end
                S_RDOUT: begin
                    r_rsp <= '{command: r_fwd[PW] ? smft_pkg::CMD_READ : smft_pkg::CMD_NONE,
                               target_page: r_fwd[PW] ? 7'(r_fwd[PW-1:0]) : 7'd0,
                               source_page: 7'd0, erase_block: 4'd0, page_owner: r_lp,
                               status: r_fwd[PW] ? smft_pkg::ST_OK : smft_pkg::ST_UNMAPPED,
                               last: 1'b1};
                    r_vld   <= 1'b1;
                    r_state <= S_OUT;
                end
                // Erased page search: read each page's mark, then test it
                S_SCAN, S_SCAN2: begin
                    if (!r_chk) begin
                        if (r_idx == XW'(TP)) begin
                            if (r_state == S_SCAN) begin
                                r_idx   <= '0;
                                r_best  <= '0;
                                r_found <= 1'b0;
                                r_state <= S_GCB;
                            end else begin
                                r_state <= S_NONE;
                            end
                        end else begin
                            r_mark <= mark_mem[pidx];
                            r_chk  <= 1'b1;
                        end
                    end else begin
                        r_chk <= 1'b0;
                        if (pidx[PW-1:OW] != r_spare && r_mark == smft_pkg::MK_ERASED) begin
                            r_fresh <= pidx;
                            r_state <= S_FMRD;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                // Victim search, one block per cycle
                S_GCB: begin
                    if (r_idx == XW'(BLOCK_COUNT)) begin
                        if (r_found) begin
                            r_idx   <= '0;
                            r_dst   <= {r_spare, OW'(0)};
                            r_state <= S_GCP;
                        end else begin
                            r_state <= S_NONE;
                        end
                    end else begin
                        if (r_idx[BW-1:0] != r_spare && r_inv[r_idx[BW-1:0]] > r_best) begin
                            r_best  <= r_inv[r_idx[BW-1:0]];
                            r_vict  <= r_idx[BW-1:0];
                            r_found <= 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // Victim page walk
                S_GCP: begin
                    if (r_idx == XW'(PAGES_IN_BLOCK)) begin
                        r_state <= S_ERASE;
                    end else begin
                        r_old   <= {r_vict, r_idx[OW-1:0]};
                        r_mark  <= mark_mem[{r_vict, r_idx[OW-1:0]}];
                        r_rev   <= rev_mem[{r_vict, r_idx[OW-1:0]}];
                        mark_mem[{r_vict, r_idx[OW-1:0]}] <= smft_pkg::MK_ERASED;
                        r_state <= S_GCPR;
                    end
                end
                S_GCPR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_mark == smft_pkg::MK_VALID) begin
                        mark_mem[r_dst] <= smft_pkg::MK_VALID;
                        rev_mem[r_dst]  <= r_rev;
                        fwd_mem[r_rev]  <= {1'b1, r_dst};
                        r_rsp <= '{command: smft_pkg::CMD_COPY, target_page: 7'(r_dst),
                                   source_page: 7'(r_old), erase_block: 4'd0,
                                   page_owner: 7'(r_rev), status: smft_pkg::ST_OK,
                                   last: 1'b0};
                        r_dst   <= r_dst + 1'b1;
                        r_vld   <= 1'b1;
                        r_ret   <= S_GCP;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_GCP;
                    end
                end
                S_ERASE: begin
                    r_inv[r_vict] <= '0;
                    r_spare <= r_vict;
                    r_rsp <= '{command: smft_pkg::CMD_ERASE, target_page: 7'd0,
                               source_page: 7'd0, erase_block: 4'(r_vict),
                               page_owner: 7'd0, status: smft_pkg::ST_OK, last: 1'b0};
                    r_vld   <= 1'b1;
                    r_idx   <= '0;
                    r_ret   <= S_SCAN2;
                    r_state <= S_OUT;
                end
                S_FMRD: begin
                    r_fwd   <= fwd_mem[r_lp[LW-1:0]];
                    r_state <= S_FMR;
                end
                S_FMR: begin
                    r_old   <= r_fwd[PW-1:0];
                    r_state <= r_fwd[PW] ? S_INV : S_PROG;
                end
                S_INV: begin
                    mark_mem[r_old] <= smft_pkg::MK_INVALID;
                    r_inv[r_old[PW-1:OW]] <= r_inv[r_old[PW-1:OW]] + 1'b1;
                    r_rsp <= '{command: smft_pkg::CMD_INVALIDATE, target_page: 7'(r_old),
                               source_page: 7'd0, erase_block: 4'd0, page_owner: r_lp,
                               status: smft_pkg::ST_OK, last: 1'b0};
                    r_vld   <= 1'b1;
                    r_ret   <= S_PROG;
                    r_state <= S_OUT;
                end
                S_PROG: begin
                    mark_mem[r_fresh] <= smft_pkg::MK_VALID;
                    rev_mem[r_fresh]  <= r_lp[LW-1:0];
                    fwd_mem[r_lp[LW-1:0]] <= {1'b1, r_fresh};
                    r_rsp <= '{command: smft_pkg::CMD_PROGRAM, target_page: 7'(r_fresh),
                               source_page: 7'd0, erase_block: 4'd0, page_owner: r_lp,
                               status: smft_pkg::ST_OK, last: 1'b1};
                    r_vld   <= 1'b1;
                    r_state <= S_OUT;
                end
                S_NONE: begin
                    r_rsp <= '{command: smft_pkg::CMD_NONE, target_page: 7'd0,
                               source_page: 7'd0, erase_block: 4'd0, page_owner: r_lp,
                               status: (r_wr ? smft_pkg::ST_NO_SPACE : smft_pkg::ST_UNMAPPED),
                               last: 1'b1};
                    r_vld   <= 1'b1;
                    r_state <= S_OUT;
                end
                // Hold the beat until the receiver takes it
                S_OUT: begin
                    if (!i_rsp_stall) begin
                        r_vld   <= 1'b0;
                        r_state <= r_rsp.last ? S_IDLE : r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_vld_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> r_state == S_OUT) else $error("beat outside output state");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_vld) else $error("beat while idle");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !i_rsp_stall && r_rsp.last) |=> r_state == S_IDLE)
        else $error("no return to idle after last beat");
`endif
endmodule
